// File: design/spd_pkg.sv
// Shared types and constants for the step peak detector.
package spd_pkg;

  localparam int unsigned WLEN_W     = 6;
  localparam int unsigned THR_W      = 15;
  localparam int unsigned HOLDOFF_W  = 6;
  localparam int unsigned SUM_OUT_W  = 7;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 15;

  localparam logic [HOLDOFF_W-1:0] HOLDOFF_MAX = '1;

  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LENGTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MOVE_THRESHOLD = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TRIGGER_LEVEL  = 2'd2;

  localparam logic [WLEN_W-1:0] WINDOW_LENGTH_RST  = 6'd8;
  localparam logic [THR_W-1:0]  MOVE_THRESHOLD_RST = 15'd256;
  localparam logic [THR_W-1:0]  TRIGGER_LEVEL_RST  = 15'd4096;

  // Direction codes held in the window, two's complement
  localparam logic [1:0] DIR_NONE = 2'b00;
  localparam logic [1:0] DIR_FALL = 2'b01;
  localparam logic [1:0] DIR_RISE = 2'b11;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EVAL,
    ST_SUM,
    ST_DECIDE
  } spd_state_e;

  typedef struct packed {
    logic capture;
    logic eval;
    logic accum;
    logic finish;
  } spd_cmd_t;

  typedef struct packed {
    logic last_tap;
    logic out_free;
  } spd_status_t;

endpackage

// File: design/spd_ctrl.sv
// Sequencer for the step peak detector: capture, evaluate, sum, decide.
module spd_ctrl
  import spd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  spd_status_t status_i,
  output spd_cmd_t    cmd_o
);

  spd_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_EVAL;
        end
      end
      ST_EVAL: begin
        cmd_o.eval = 1'b1;
        state_d    = ST_SUM;
      end
      ST_SUM: begin
        cmd_o.accum = 1'b1;
        if (status_i.last_tap) begin
          state_d = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        // hold until the output register can take the result
        if (status_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign in_stall_o = (state_q != ST_IDLE);

endmodule

// File: design/spd_datapath.sv
// Datapath: config registers, sample state, direction window, summing and output register.
module spd_datapath
  import spd_pkg::*;
#(
  parameter int unsigned MAX_WINDOW   = 32,
  parameter int unsigned SAMPLE_WIDTH = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  spd_cmd_t                       cmd_i,
  output spd_status_t                    status_o,
  input  logic signed [SAMPLE_WIDTH-1:0] sample_i,
  input  logic                           cfg_we_i,
  input  logic [CFG_IDX_W-1:0]           cfg_index_i,
  input  logic [CFG_DATA_W-1:0]          cfg_data_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic                           step_o,
  output logic                           moved_o,
  output logic signed [SUM_OUT_W-1:0]    direction_sum_o
);

  localparam int unsigned NW    = $clog2(MAX_WINDOW + 1);
  localparam int unsigned IW    = $clog2(MAX_WINDOW);
  localparam int unsigned SUM_W = NW + 1;
  localparam int unsigned LW    = (NW > WLEN_W) ? NW : WLEN_W;
  localparam int unsigned CW    = ((SAMPLE_WIDTH > THR_W) ? SAMPLE_WIDTH : THR_W) + 2;
  localparam int unsigned SE_W  = SUM_W + SUM_OUT_W;

  logic [WLEN_W-1:0] win_len_q;
  logic [THR_W-1:0]  move_thr_q;
  logic [THR_W-1:0]  trig_q;

  logic signed [SAMPLE_WIDTH-1:0] sample_q;
  logic signed [SAMPLE_WIDTH-1:0] last_q;
  logic [1:0]                     win_q [MAX_WINDOW];
  logic [HOLDOFF_W-1:0]           hold_q;
  logic                           moved_q;
  logic signed [SUM_W-1:0]        sum_q;
  logic [IW-1:0]                  idx_q;

  logic                           out_valid_q;
  logic                           step_q;
  logic                           moved_out_q;
  logic signed [SUM_OUT_W-1:0]    sum_out_q;

  // effective window length, clamped to 1..MAX_WINDOW
  logic [LW-1:0] wl_ext;
  logic [NW-1:0] n_eff;

  always_comb begin
    wl_ext = LW'(win_len_q);
    if (wl_ext == '0) begin
      n_eff = NW'(1);
    end else if (wl_ext > LW'(MAX_WINDOW)) begin
      n_eff = NW'(MAX_WINDOW);
    end else begin
      n_eff = NW'(wl_ext);
    end
  end

  // movement compare
  logic signed [CW-1:0] s_ext, last_ext, thr_ext, trig_ext;
  logic                 rise, fall;

  assign s_ext    = CW'(sample_q);
  assign last_ext = CW'(last_q);
  assign thr_ext  = CW'($signed({1'b0, move_thr_q}));
  assign trig_ext = CW'($signed({1'b0, trig_q}));
  assign rise     = last_ext < (s_ext - thr_ext);
  assign fall     = !rise && (last_ext > (s_ext + thr_ext));

  // window tap selected by the summing counter
  logic signed [1:0] tap;
  assign tap = win_q[idx_q];

  assign status_o.last_tap = (idx_q == IW'(n_eff - NW'(1)));
  assign status_o.out_free = !out_valid_q || !out_stall_i;

  // step decision
  logic step_hit;
  logic hold_gt;
  logic trig_hit;

  assign hold_gt  = (LW + 1)'(hold_q) > (LW + 1)'(n_eff);
  assign trig_hit = (s_ext >= trig_ext) || (s_ext <= -trig_ext);
  assign step_hit = moved_q && (sum_q == '0) && hold_gt && trig_hit;

  // clamp the window sum into the output field
  logic signed [SE_W-1:0]      sum_se;
  logic signed [SUM_OUT_W-1:0] sum_sat;

  always_comb begin
    sum_se = SE_W'(sum_q);
    if (sum_se > SE_W'(63)) begin
      sum_sat = SUM_OUT_W'(63);
    end else if (sum_se < -SE_W'(64)) begin
      sum_sat = SUM_OUT_W'(-64);
    end else begin
      sum_sat = SUM_OUT_W'(sum_se);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_len_q  <= WINDOW_LENGTH_RST;
      move_thr_q <= MOVE_THRESHOLD_RST;
      trig_q     <= TRIGGER_LEVEL_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_WINDOW_LENGTH:  win_len_q  <= cfg_data_i[WLEN_W-1:0];
        CFG_MOVE_THRESHOLD: move_thr_q <= cfg_data_i[THR_W-1:0];
        CFG_TRIGGER_LEVEL:  trig_q     <= cfg_data_i[THR_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      sample_q <= sample_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q  <= '0;
      hold_q  <= '0;
      moved_q <= 1'b0;
      for (int i = 0; i < MAX_WINDOW; i++) begin
        win_q[i] <= DIR_NONE;
      end
    end else begin
      if (cmd_i.eval) begin
        moved_q <= rise || fall;
        if (rise || fall) begin
          last_q <= sample_q;
          for (int i = MAX_WINDOW - 1; i > 0; i--) begin
            win_q[i] <= win_q[i-1];
          end
          win_q[0] <= rise ? DIR_RISE : DIR_FALL;
          if (hold_q != HOLDOFF_MAX) begin
            hold_q <= hold_q + HOLDOFF_W'(1);
          end
        end
      end else if (cmd_i.finish && step_hit) begin
        hold_q <= '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.eval) begin
      sum_q <= '0;
      idx_q <= '0;
    end else if (cmd_i.accum) begin
      sum_q <= sum_q + SUM_W'(tap);
      idx_q <= idx_q + IW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.finish) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      step_q      <= step_hit;
      moved_out_q <= moved_q;
      sum_out_q   <= sum_sat;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign step_o          = step_q;
  assign moved_o         = moved_out_q;
  assign direction_sum_o = sum_out_q;

endmodule

// File: design/step_peak_detector.sv
// Step peak detector top level: sequencer plus datapath, config write port.
// Each item is captured, evaluated, summed over n = clamped window_length entries
// at one entry per cycle, and decided; no new item is taken in before its result is loaded.
// The output register holds a result while the next item is taken in.
// Reset (async, active low) restores config defaults, clears the window,
// hold-off count and last sample, and empties the output register.
module step_peak_detector
  import spd_pkg::*;
#(
  parameter int unsigned MAX_WINDOW   = 32,
  parameter int unsigned SAMPLE_WIDTH = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic signed [SAMPLE_WIDTH-1:0] sample_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic                           step_o,
  output logic                           moved_o,
  output logic signed [SUM_OUT_W-1:0]    direction_sum_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]           cfg_index_i,
  input  logic [CFG_DATA_W-1:0]          cfg_data_i
);

  spd_cmd_t    cmd;
  spd_status_t status;

  assign cfg_ready_o = 1'b1;

  spd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  spd_datapath #(
    .MAX_WINDOW   (MAX_WINDOW),
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .status_o        (status),
    .sample_i        (sample_i),
    .cfg_we_i        (cfg_valid_i && cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .step_o          (step_o),
    .moved_o         (moved_o),
    .direction_sum_o (direction_sum_o)
  );

  a_capture_then_eval: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.capture |=> cmd.eval)
    else $error("evaluation did not follow a sample transfer");

  a_finish_needs_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.finish |-> status.out_free)
    else $error("result loaded over an untaken result");

  a_step_consistent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && step_o) |-> (moved_o && (direction_sum_o == '0)))
    else $error("step flagged without movement or with nonzero window sum");

  a_accept_only_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |-> cmd.capture)
    else $error("sample transfer without capture");

endmodule

// File: tb/sv/spd_checker.sv
// Checker for the step peak detector: watches all three channels, predicts and compares results.
`timescale 1ns / 100ps
module spd_checker
  import spd_pkg::*;
#(
  parameter int unsigned MAX_WINDOW   = 32,
  parameter int unsigned SAMPLE_WIDTH = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  input  logic                           in_stall_i,
  input  logic signed [SAMPLE_WIDTH-1:0] sample_i,
  input  logic                           out_valid_i,
  input  logic                           out_stall_i,
  input  logic                           step_i,
  input  logic                           moved_i,
  input  logic signed [SUM_OUT_W-1:0]    direction_sum_i,
  input  logic                           cfg_valid_i,
  input  logic                           cfg_ready_i,
  input  logic [CFG_IDX_W-1:0]           cfg_index_i,
  input  logic [CFG_DATA_W-1:0]          cfg_data_i,
  output int                             fail_count_o,
  output int                             pending_o,
  output int                             result_count_o,
  output int                             move_count_o,
  output int                             step_count_o
);

  typedef struct packed {
    logic                        step;
    logic                        moved;
    logic signed [SUM_OUT_W-1:0] dsum;
  } step_result_t;

  step_result_t expected_steps[$];

  logic [WLEN_W-1:0]              win_len;
  logic [THR_W-1:0]               move_thr;
  logic [THR_W-1:0]               trig_lvl;
  logic signed [SAMPLE_WIDTH-1:0] anchor_sample;
  logic [1:0]                     dir_hist [MAX_WINDOW];
  logic [HOLDOFF_W-1:0]           holdoff;

  int fails   = 0;
  int results = 0;
  int moves   = 0;
  int steps   = 0;

  // Advance the detector state by one sample and return what the block must report.
  function automatic step_result_t detect_step(input logic signed [SAMPLE_WIDTH-1:0] smp);
    step_result_t r;
    int s;
    int n;
    int sum;
    logic [1:0] dir;
    r   = '0;
    s   = smp;
    sum = 0;
    dir = DIR_NONE;
    n   = (win_len == 0) ? 1 : (win_len > MAX_WINDOW) ? MAX_WINDOW : win_len;
    if (int'(anchor_sample) < s - int'(move_thr)) begin
      dir = DIR_RISE;
    end else if (int'(anchor_sample) > s + int'(move_thr)) begin
      dir = DIR_FALL;
    end
    r.moved = (dir != DIR_NONE);
    if (r.moved) begin
      anchor_sample = smp;
      for (int i = MAX_WINDOW - 1; i > 0; i--) dir_hist[i] = dir_hist[i-1];
      dir_hist[0] = dir;
      if (holdoff != HOLDOFF_MAX) holdoff++;
    end
    for (int i = 0; i < n; i++) sum += int'($signed(dir_hist[i]));
    if (r.moved && sum == 0 && int'(holdoff) > n &&
        (s >= int'(trig_lvl) || s <= -int'(trig_lvl))) begin
      r.step  = 1'b1;
      holdoff = '0;
    end
    // clamp into the output field
    if (sum > 63) sum = 63;
    if (sum < -64) sum = -64;
    r.dsum = sum[SUM_OUT_W-1:0];
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    step_result_t want;
    step_result_t got;
    if (!rst_ni) begin
      win_len       = WINDOW_LENGTH_RST;
      move_thr      = MOVE_THRESHOLD_RST;
      trig_lvl      = TRIGGER_LEVEL_RST;
      anchor_sample = '0;
      holdoff       = '0;
      for (int i = 0; i < MAX_WINDOW; i++) dir_hist[i] = DIR_NONE;
      expected_steps.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_WINDOW_LENGTH:  win_len  = cfg_data_i[WLEN_W-1:0];
          CFG_MOVE_THRESHOLD: move_thr = cfg_data_i[THR_W-1:0];
          CFG_TRIGGER_LEVEL:  trig_lvl = cfg_data_i[THR_W-1:0];
          default: ;
        endcase
      end
      if (out_valid_i && !out_stall_i) begin
        got = '{step: step_i, moved: moved_i, dsum: direction_sum_i};
        results++;
        if (expected_steps.size() == 0) begin
          $display("%0t: unexpected result, step %0b moved %0b sum %0d", $time,
                   got.step, got.moved, got.dsum);
          fails++;
        end else begin
          want = expected_steps.pop_front();
          moves += want.moved;
          steps += want.step;
          if (got.step !== want.step) begin
            $display("%0t: step mismatch, expected %0b, got %0b", $time, want.step, got.step);
            fails++;
          end
          if (got.moved !== want.moved) begin
            $display("%0t: moved mismatch, expected %0b, got %0b", $time,
                     want.moved, got.moved);
            fails++;
          end
          if (got.dsum !== want.dsum) begin
            $display("%0t: direction_sum mismatch, expected %0d, got %0d", $time,
                     want.dsum, got.dsum);
            fails++;
          end
        end
      end
      if (in_valid_i && !in_stall_i) expected_steps.push_back(detect_step(sample_i));
    end
    fail_count_o   <= fails;
    pending_o      <= expected_steps.size();
    result_count_o <= results;
    move_count_o   <= moves;
    step_count_o   <= steps;
  end

endmodule

// File: tb/sv/tb.sv
// Testbench top for the step peak detector: clock, reset, stimulus, stalls and verdict.
`timescale 1ns / 100ps
module tb
  import spd_pkg::*;
();

  localparam int unsigned MAX_WINDOW   = 32;
  localparam int unsigned SAMPLE_WIDTH = 16;
  localparam int          NUM_PHASES   = 12;
  localparam int          PHASE_ITEMS  = 125;
  localparam int          DRAIN_CYCLES = 40;

  // Index past the register list; writes to it must have no effect
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

  logic                           clk_i;
  logic                           rst_ni;
  logic                           in_valid_i;
  logic                           in_stall_o;
  logic signed [SAMPLE_WIDTH-1:0] sample_i;
  logic                           out_valid_o;
  logic                           out_stall_i;
  logic                           step_o;
  logic                           moved_o;
  logic signed [SUM_OUT_W-1:0]    direction_sum_o;
  logic                           cfg_valid_i;
  logic                           cfg_ready_o;
  logic [CFG_IDX_W-1:0]           cfg_index_i;
  logic [CFG_DATA_W-1:0]          cfg_data_i;

  int fail_count;
  int pending;
  int result_count;
  int move_count;
  int step_count;

  int in_idle_pct  = 11;
  int out_idle_pct = 60;
  int settings     = 1;

  logic signed [SAMPLE_WIDTH-1:0] last_sent = '0;

  step_peak_detector #(
    .MAX_WINDOW  (MAX_WINDOW),
    .SAMPLE_WIDTH(SAMPLE_WIDTH)
  ) u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .sample_i       (sample_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .step_o         (step_o),
    .moved_o        (moved_o),
    .direction_sum_o(direction_sum_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  spd_checker #(
    .MAX_WINDOW  (MAX_WINDOW),
    .SAMPLE_WIDTH(SAMPLE_WIDTH)
  ) u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_i     (in_stall_o),
    .sample_i       (sample_i),
    .out_valid_i    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .step_i         (step_o),
    .moved_i        (moved_o),
    .direction_sum_i(direction_sum_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_i    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .fail_count_o   (fail_count),
    .pending_o      (pending),
    .result_count_o (result_count),
    .move_count_o   (move_count),
    .step_count_o   (step_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      out_stall_i <= ($urandom_range(99) < out_idle_pct);
    end
  end

  initial begin
    #10_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  function automatic logic signed [SAMPLE_WIDTH-1:0] clip_sample(input int v);
    if (v > 32767) return 16'sh7FFF;
    if (v < -32768) return 16'sh8000;
    return v[SAMPLE_WIDTH-1:0];
  endfunction

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic send_sample(input logic signed [SAMPLE_WIDTH-1:0] v);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    sample_i   = v;
    last_sent  = v;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned data);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = data[CFG_DATA_W-1:0];
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
  endtask

  // Drop input valid and wait until every expected result has been checked.
  task automatic drain;
    in_valid_i = 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  initial begin
    int wlen;
    int thr;
    int trig;
    int n_eff;
    int peak;
    int len;
    int sgn;
    int delta;
    int k;
    int directed [6];
    directed = '{0, 256, 257, 32767, -32768, -32768};

    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    sample_i    = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = CFG_WINDOW_LENGTH;
    cfg_data_i  = '0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: reset settings, a write past the register list, field extremes,
    // threshold edge, then a clean oscillation long enough to flag a step.
    write_reg(CFG_SPARE, 32'h7FFF);
    cfg_valid_i = 1'b0;
    foreach (directed[i]) send_sample(clip_sample(directed[i]));
    for (int i = 0; i < 14; i++) send_sample(clip_sample((i % 2) ? -5000 : 5000));
    drain();

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        0: begin wlen = 0;  thr = 0;     trig = 0;     end
        1: begin wlen = 63; thr = 32767; trig = 32767; end
        2: begin
          wlen = 32;
          thr  = $urandom_range(0, 800);
          trig = $urandom_range(0, 8000);
        end
        3: begin wlen = 1; thr = 0; trig = $urandom_range(0, 8000); end
        default: begin
          wlen = ($urandom_range(9) == 0) ? $urandom_range(0, 63) : $urandom_range(2, 10);
          thr  = $urandom_range(0, 1500);
          trig = $urandom_range(0, 12000);
        end
      endcase
      if (ph < 4) begin
        in_idle_pct  = 11;
        out_idle_pct = 60;
      end else if (ph < 8) begin
        in_idle_pct  = 60;
        out_idle_pct = 11;
      end else begin
        in_idle_pct  = 0;
        out_idle_pct = 0;
      end
      write_reg(CFG_WINDOW_LENGTH, wlen);
      write_reg(CFG_MOVE_THRESHOLD, thr);
      write_reg(CFG_TRIGGER_LEVEL, trig);
      cfg_valid_i = 1'b0;
      settings++;
      n_eff = (wlen == 0) ? 1 : (wlen > MAX_WINDOW) ? MAX_WINDOW : wlen;

      k = 0;
      while (k < PHASE_ITEMS) begin
        if ($urandom_range(99) < 20) begin
          // full-range noise
          send_sample(16'($urandom));
          k++;
        end else begin
          // walking-like oscillation with peaks near the trigger level
          peak = ((trig > thr / 2 + 1) ? trig : thr / 2 + 1) + $urandom_range(0, 1500) - 300;
          if (peak < 1) peak = 1;
          len = $urandom_range(4, 3 * n_eff + 8);
          sgn = $urandom_range(1) ? 1 : -1;
          for (int j = 0; j < len && k < PHASE_ITEMS; j++) begin
            if ($urandom_range(99) < 15) begin
              // jitter under the threshold
              delta = $urandom_range(0, thr / 2);
              send_sample(clip_sample(int'(last_sent) + ($urandom_range(1) ? delta : -delta)));
            end else begin
              // occasionally repeat a direction to break the pattern
              if ($urandom_range(99) >= 8) sgn = -sgn;
              send_sample(clip_sample(sgn * peak + $urandom_range(0, 200) - 100));
            end
            k++;
          end
        end
      end
      drain();
    end

    $display("Covered %0d results (%0d movements, %0d steps) over %0d register settings",
             result_count, move_count, step_count, settings);
    $display("including zero and oversized window lengths and both threshold extremes.");
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// File: files.f
design/spd_pkg.sv
design/spd_ctrl.sv
design/spd_datapath.sv
design/step_peak_detector.sv
tb/sv/spd_checker.sv
tb/sv/tb.sv
